// ===== design/ucp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucp_pkg
// shared types and constants for the command parser with timed resend
// ----------------------------------------------------------------------------
package ucp_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int SAMPLE_W    = 12;
    localparam int TICKS_W     = 16;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    localparam logic [TICKS_W-1:0] RETRY_RESET = 16'd3000;

    // item kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // reply kinds
    localparam logic KIND_NEW    = 1'b0;
    localparam logic KIND_REPEAT = 1'b1;

    // command characters
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_T    = 8'h54;

    typedef struct packed {
        logic                action;
        logic [7:0]          rx_byte;
        logic [SAMPLE_W-1:0] adc_sample;
    } t_in_item;

    typedef struct packed {
        logic                send_kind;
        logic [SAMPLE_W-1:0] reply_value;
    } t_out_item;

    // classified item handed from parser to reply engine
    typedef struct packed {
        logic                tick;
        logic                set_ok;
        logic                set_rst;
        logic [SAMPLE_W-1:0] sample;
    } t_event;

endpackage
`default_nettype wire

// ===== design/ucp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucp_front
// command parser and two-entry event queue toward the reply engine
// ----------------------------------------------------------------------------
module ucp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire ucp_pkg::t_in_item i_in_item,
    output logic                   o_ev_valid,
    output ucp_pkg::t_event        o_ev,
    input  wire logic              i_ev_pop
);
    import ucp_pkg::*;

    typedef enum logic [3:0] {
        PS_WAIT, PS_LISTEN, PS_GOT_O, PS_GOT_K, PS_EXE_OK,
        PS_GOT_R, PS_GOT_S, PS_GOT_T, PS_EXE_RST
    } t_pstate;

    t_pstate     r_state, n_state;
    t_event      r_ev_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        accept;
    logic        pop_ok;
    logic        set_ok, set_rst;
    t_event      ev_new;

    function automatic t_pstate step_or_restart(input logic [7:0] ch,
                                                input logic [7:0] want,
                                                input t_pstate    nxt);
        t_pstate s;
        if (ch == want) begin
            s = nxt;
        end else if (ch == CH_BANG) begin
            s = PS_LISTEN;
        end else begin
            s = PS_WAIT;
        end
        return s;
    endfunction

    assign full       = (r_count == 2'd2);
    assign accept     = push && !full;
    assign o_ev_valid = (r_count != 2'd0);
    assign pop_ok     = i_ev_pop && o_ev_valid;
    assign o_ev       = r_ev_mem[r_rd_ptr];

    always_comb begin
        n_state = r_state;
        set_ok  = 1'b0;
        set_rst = 1'b0;
        unique case (r_state)
            PS_WAIT: begin
                if (i_in_item.rx_byte == CH_BANG) n_state = PS_LISTEN;
            end
            PS_LISTEN: begin
                if (i_in_item.rx_byte == CH_BANG) begin
                    n_state = PS_LISTEN;
                end else if (i_in_item.rx_byte == CH_O) begin
                    n_state = PS_GOT_O;
                end else if (i_in_item.rx_byte == CH_R) begin
                    n_state = PS_GOT_R;
                end else begin
                    n_state = PS_WAIT;
                end
            end
            PS_GOT_O: n_state = step_or_restart(i_in_item.rx_byte, CH_K, PS_GOT_K);
            PS_GOT_K: begin
                n_state = step_or_restart(i_in_item.rx_byte, CH_HASH, PS_EXE_OK);
                set_ok  = (i_in_item.rx_byte == CH_HASH);
            end
            PS_GOT_R: n_state = step_or_restart(i_in_item.rx_byte, CH_S, PS_GOT_S);
            PS_GOT_S: n_state = step_or_restart(i_in_item.rx_byte, CH_T, PS_GOT_T);
            PS_GOT_T: begin
                n_state = step_or_restart(i_in_item.rx_byte, CH_HASH, PS_EXE_RST);
                set_rst = (i_in_item.rx_byte == CH_HASH);
            end
            PS_EXE_OK, PS_EXE_RST: begin
                n_state = (i_in_item.rx_byte == CH_BANG) ? PS_LISTEN : PS_WAIT;
            end
            default: n_state = PS_WAIT;
        endcase
    end

    always_comb begin
        ev_new.tick    = (i_in_item.action == ACT_TICK);
        ev_new.set_ok  = (i_in_item.action == ACT_BYTE) && set_ok;
        ev_new.set_rst = (i_in_item.action == ACT_BYTE) && set_rst;
        ev_new.sample  = i_in_item.adc_sample & SAMPLE_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= PS_WAIT;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (accept && (i_in_item.action == ACT_BYTE)) r_state <= n_state;
            if (accept) r_wr_ptr <= ~r_wr_ptr;
            if (pop_ok) r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(accept) - 2'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_ev_mem[r_wr_ptr] <= ev_new;
    end

endmodule
`default_nettype wire

// ===== design/ucp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucp_back
// reply engine with retry countdown and two-entry result queue
// ----------------------------------------------------------------------------
module ucp_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [ucp_pkg::TICKS_W-1:0]    i_retry_ticks,
    input  wire logic                           i_ev_valid,
    input  wire ucp_pkg::t_event                i_ev,
    output logic                                o_ev_pop,
    output logic                                empty,
    input  wire logic                           pop,
    output ucp_pkg::t_out_item                  o_out_item
);
    import ucp_pkg::*;

    logic                r_link;
    logic                r_ok_pend, n_ok_pend;
    logic                r_rst_pend, n_rst_pend;
    logic [TICKS_W-1:0]  r_count_dn, n_count_dn;
    logic [SAMPLE_W-1:0] r_held, n_held;
    logic                n_link;
    logic                emit;
    t_out_item           res_new;
    logic                ok_now, rst_now;

    t_out_item           r_res_mem [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_res_cnt;
    logic                res_full;
    logic                res_pop;

    assign res_full   = (r_res_cnt == 2'd2);
    assign empty      = (r_res_cnt == 2'd0);
    assign res_pop    = pop && !empty;
    assign o_out_item = r_res_mem[r_rd_ptr];
    assign o_ev_pop   = i_ev_valid && !res_full;

    always_comb begin
        ok_now     = r_ok_pend  || i_ev.set_ok;
        rst_now    = r_rst_pend || i_ev.set_rst;
        n_link     = r_link;
        n_ok_pend  = ok_now;
        n_rst_pend = rst_now;
        n_count_dn = r_count_dn;
        n_held     = r_held;
        emit       = 1'b0;
        res_new    = '{send_kind: KIND_NEW, reply_value: i_ev.sample};
        if (!r_link) begin
            n_ok_pend = 1'b0;
            if (rst_now) begin
                n_link     = 1'b1;
                n_held     = i_ev.sample;
                n_count_dn = i_retry_ticks;
                emit       = 1'b1;
            end
        end else begin
            n_rst_pend = 1'b0;
            if (ok_now) n_link = 1'b0;
            if (i_ev.tick) begin
                if (r_count_dn <= TICKS_W'(1)) begin
                    n_count_dn = i_retry_ticks;
                    emit       = 1'b1;
                    res_new    = '{send_kind: KIND_REPEAT, reply_value: r_held};
                end else begin
                    n_count_dn = r_count_dn - TICKS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link     <= 1'b0;
            r_ok_pend  <= 1'b0;
            r_rst_pend <= 1'b0;
            r_count_dn <= '0;
            r_held     <= '0;
            r_wr_ptr   <= 1'b0;
            r_rd_ptr   <= 1'b0;
            r_res_cnt  <= 2'd0;
        end else begin
            if (o_ev_pop) begin
                r_link     <= n_link;
                r_ok_pend  <= n_ok_pend;
                r_rst_pend <= n_rst_pend;
                r_count_dn <= n_count_dn;
                r_held     <= n_held;
            end
            if (o_ev_pop && emit) r_wr_ptr <= ~r_wr_ptr;
            if (res_pop) r_rd_ptr <= ~r_rd_ptr;
            r_res_cnt <= r_res_cnt + 2'(o_ev_pop && emit) - 2'(res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ev_pop && emit) r_res_mem[r_wr_ptr] <= res_new;
    end

endmodule
`default_nettype wire

// ===== design/uart_command_parser_with_resend.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uart_command_parser_with_resend
// recognizes !RST# and !OK# in a byte stream and sends an adc reply that
// repeats on a tick countdown until acknowledged
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     push / full             i_in_item  (action, rx_byte, adc_sample)
//  result    empty / pop             o_out_item (send_kind, reply_value)
//  config    i_cfg_valid/o_cfg_ready i_cfg_data (retry_ticks)
//
//  one item per clock sustained while nothing stalls; the parser and the reply
//  engine are joined by a two-entry event queue
//  events wait in the event queue; the result queue's head drives o_out_item
//  a two-entry result queue lets input keep flowing while a result waits
//  synchronous active-low reset; retry_ticks returns to 3000
//  config is always ready; the user changes it only while the block is idle,
//  which the block itself does not enforce
// ----------------------------------------------------------------------------
module uart_command_parser_with_resend (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire ucp_pkg::t_in_item           i_in_item,
    output logic                             empty,
    input  wire logic                        pop,
    output ucp_pkg::t_out_item               o_out_item,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [ucp_pkg::TICKS_W-1:0] i_cfg_data
);
    import ucp_pkg::*;

    // retry interval register
    logic [TICKS_W-1:0] r_retry_ticks;

    // front to back event link
    logic   ev_valid;
    t_event ev;
    logic   ev_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_ticks <= RETRY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_retry_ticks <= i_cfg_data;
        end
    end

    // parser: classifies each transfer into an event
    ucp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .o_ev_valid (ev_valid),
        .o_ev       (ev),
        .i_ev_pop   (ev_pop)
    );

    // reply engine: link state, countdown and result queue
    ucp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_retry_ticks (r_retry_ticks),
        .i_ev_valid    (ev_valid),
        .i_ev          (ev),
        .o_ev_pop      (ev_pop),
        .empty         (empty),
        .pop           (pop),
        .o_out_item    (o_out_item)
    );

endmodule
`default_nettype wire

// ===== design/ucp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucp_checker
// port-level checks on the command parser, attached by bind
// ----------------------------------------------------------------------------
module ucp_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    input  wire logic                        full,
    input  wire logic                        empty,
    input  wire logic                        pop,
    input  wire ucp_pkg::t_out_item          o_out_item
);
    // reset leaves no result waiting
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // reset leaves the input side open
    a_rst_open: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input full after reset");

    // input can only fill up after a push
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

    // an untaken result stays put
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result changed");

endmodule

bind uart_command_parser_with_resend ucp_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);
`default_nettype wire
